@@ rtl/rtty_pkg.sv @@
// package for the rtty baudot receiver: codes, reset values and the ita2 character tables
`timescale 1ns / 1ps

package rtty_pkg;

    localparam int DATA_BITS = 5;
    localparam int CODE_W    = DATA_BITS;
    localparam int BITPOS_W  = 3;
    localparam int CNT_W     = 8;
    localparam int CHAR_W    = 7;
    localparam int CLASS_W   = 2;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 2;

    // tone classes
    localparam logic [CLASS_W-1:0] CLS_SPACE = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_MARK  = 2'd1;

    // sampling events
    localparam logic [EVENT_W-1:0] EV_NONE      = 2'd0;
    localparam logic [EVENT_W-1:0] EV_START     = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DATA_DONE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MARK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SPACE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SIGNAL   = 2'd3;

    localparam logic [CNT_W-1:0] IDLE_MARK_RST   = 8'd7;
    localparam logic [CNT_W-1:0] START_SPACE_RST = 8'd1;
    localparam logic [CNT_W-1:0] STOP_MARK_RST   = 8'd2;
    localparam logic [CNT_W-1:0] NO_SIGNAL_RST   = 8'd10;

    // shift codes
    localparam logic [CODE_W-1:0] CODE_FIGS = 5'd27;
    localparam logic [CODE_W-1:0] CODE_LTRS = 5'd31;

    localparam logic [CHAR_W-1:0] LETTERS_ROM [32] = '{
        7'h00, 7'h45, 7'h0A, 7'h41, 7'h20, 7'h53, 7'h49, 7'h55,
        7'h0D, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43, 7'h4B,
        7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50, 7'h51,
        7'h4F, 7'h42, 7'h47, 7'h00, 7'h4D, 7'h58, 7'h56, 7'h00
    };

    localparam logic [CHAR_W-1:0] FIGURES_ROM [32] = '{
        7'h00, 7'h33, 7'h0A, 7'h2D, 7'h20, 7'h07, 7'h38, 7'h37,
        7'h0D, 7'h24, 7'h34, 7'h27, 7'h2C, 7'h21, 7'h3A, 7'h28,
        7'h35, 7'h22, 7'h29, 7'h32, 7'h23, 7'h36, 7'h30, 7'h31,
        7'h39, 7'h3F, 7'h26, 7'h00, 7'h2E, 7'h2F, 7'h3B, 7'h00
    };

    // saturating increment at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        if (cnt == {CNT_W{1'b1}})
        begin
            return cnt;
        end
        return cnt + 1'b1;
    endfunction

endpackage

@@ rtl/rtty_baudot_receiver.sv @@
// rtty baudot receive framer with ita2 to ascii decode
`timescale 1ns / 1ps

// Takes one tone sample (space, mark, unknown) per input transfer and returns
// one result per sample: decoded character, lock and shift status, and the
// sampling event for the bit timer. A sample is taken in every cycle unless the
// output stalls; its result is registered in the output register at the input
// transfer, and the next sample is taken in the same cycle the previous result
// is taken. The throughput is set by the counter and compare updates of the
// framer state, done once per sample. Thresholds are written over the cfg
// channel (index 0 idle marks, 1 start spaces, 2 stop marks, 3 unknowns to
// reset), always ready, and should only be changed while the framer is idle.
module rtty_baudot_receiver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rtty_pkg::CLASS_W-1:0]       tone_class,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               char_valid,
    output logic [rtty_pkg::CHAR_W-1:0]        ascii_char,
    output logic                               locked,
    output logic                               figures_mode,
    output logic [rtty_pkg::EVENT_W-1:0]       sampling_event,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rtty_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtty_pkg::CNT_W-1:0]         cfg_data
);

    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_START = 2'd1,
        ST_DATA  = 2'd2,
        ST_STOP  = 2'd3
    } state_t;

    state_t                          state_reg, state_next;
    logic [rtty_pkg::CNT_W-1:0]      mark_cnt_reg, mark_cnt_next;
    logic [rtty_pkg::CNT_W-1:0]      space_cnt_reg, space_cnt_next;
    logic [rtty_pkg::CNT_W-1:0]      idle_cnt_reg, idle_cnt_next;
    logic [rtty_pkg::CNT_W-1:0]      unknown_cnt_reg, unknown_cnt_next;
    logic [rtty_pkg::BITPOS_W-1:0]   bit_pos_reg, bit_pos_next;
    logic [rtty_pkg::CODE_W-1:0]     code_reg, code_next;
    logic                            figures_reg, figures_next;
    logic                            lock_reg, lock_next;

    logic [rtty_pkg::CNT_W-1:0]      idle_thr_reg, start_thr_reg, stop_thr_reg, nosig_thr_reg;

    logic                            out_valid_reg;
    logic [rtty_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic [rtty_pkg::EVENT_W-1:0]    event_reg, event_next;

    logic                            is_space, is_mark, is_unknown;
    logic                            frame_hit, run_hit, skip_checks;
    logic [rtty_pkg::BITPOS_W-1:0]   bit_pos_inc;
    logic                            in_xfer;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign is_space   = (tone_class == rtty_pkg::CLS_SPACE);
    assign is_mark    = (tone_class == rtty_pkg::CLS_MARK);
    assign is_unknown = !is_space && !is_mark;

    always_comb
    begin
        state_next       = state_reg;
        mark_cnt_next    = mark_cnt_reg;
        space_cnt_next   = space_cnt_reg;
        idle_cnt_next    = idle_cnt_reg;
        unknown_cnt_next = unknown_cnt_reg;
        bit_pos_next     = bit_pos_reg;
        code_next        = code_reg;
        figures_next     = figures_reg;
        lock_next        = lock_reg;
        char_next        = '0;
        event_next       = rtty_pkg::EV_NONE;
        skip_checks      = 1'b0;
        frame_hit        = 1'b0;
        run_hit          = 1'b0;
        bit_pos_inc      = bit_pos_reg + 1'b1;

        case (state_reg)
            ST_INIT:
            begin
                if (is_mark)
                begin
                    frame_hit     = (mark_cnt_reg >= idle_thr_reg);
                    mark_cnt_next = rtty_pkg::sat_inc(mark_cnt_reg);
                    if (frame_hit)
                    begin
                        mark_cnt_next    = '0;
                        space_cnt_next   = '0;
                        bit_pos_next     = '0;
                        code_next        = '0;
                        lock_next        = 1'b0;
                        idle_cnt_next    = '0;
                        unknown_cnt_next = '0;
                        figures_next     = 1'b1;
                        state_next       = ST_START;
                    end
                end
            end
            ST_START:
            begin
                if (is_space)
                begin
                    frame_hit      = (space_cnt_reg >= start_thr_reg);
                    space_cnt_next = rtty_pkg::sat_inc(space_cnt_reg);
                    if (frame_hit)
                    begin
                        event_next       = rtty_pkg::EV_START;
                        mark_cnt_next    = '0;
                        space_cnt_next   = '0;
                        unknown_cnt_next = '0;
                        bit_pos_next     = '0;
                        code_next        = '0;
                        state_next       = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (!is_unknown)
                begin
                    // bit position stays below the number of data bits while in data
                    if (is_mark && (bit_pos_reg < rtty_pkg::BITPOS_W'(rtty_pkg::DATA_BITS)))
                    begin
                        code_next[bit_pos_reg] = 1'b1;
                    end
                    bit_pos_next = bit_pos_inc;
                    if (bit_pos_inc >= rtty_pkg::BITPOS_W'(rtty_pkg::DATA_BITS))
                    begin
                        event_next       = rtty_pkg::EV_DATA_DONE;
                        mark_cnt_next    = '0;
                        space_cnt_next   = '0;
                        unknown_cnt_next = '0;
                        bit_pos_next     = '0;
                        state_next       = ST_STOP;
                    end
                end
            end
            default:
            begin
                if (is_mark)
                begin
                    frame_hit     = (mark_cnt_reg >= stop_thr_reg);
                    mark_cnt_next = rtty_pkg::sat_inc(mark_cnt_reg);
                    if (frame_hit)
                    begin
                        mark_cnt_next    = '0;
                        unknown_cnt_next = '0;
                        space_cnt_next   = '0;
                        bit_pos_next     = '0;
                        state_next       = ST_START;
                        lock_next        = 1'b1;
                        if (code_reg == rtty_pkg::CODE_FIGS)
                        begin
                            figures_next = 1'b1;
                        end
                        else if (code_reg == rtty_pkg::CODE_LTRS)
                        begin
                            figures_next = 1'b0;
                        end
                        else
                        begin
                            char_next   = figures_reg ? rtty_pkg::FIGURES_ROM[code_reg]
                                                      : rtty_pkg::LETTERS_ROM[code_reg];
                            skip_checks = 1'b1;
                        end
                    end
                end
            end
        endcase

        // run checks: long unknown run to init, long mark run to start search
        if (!skip_checks)
        begin
            if (is_unknown)
            begin
                run_hit          = (unknown_cnt_next >= nosig_thr_reg);
                unknown_cnt_next = rtty_pkg::sat_inc(unknown_cnt_next);
                if (run_hit)
                begin
                    lock_next        = 1'b0;
                    figures_next     = 1'b1;
                    idle_cnt_next    = '0;
                    unknown_cnt_next = '0;
                    state_next       = ST_INIT;
                end
            end
            else if (is_mark)
            begin
                run_hit       = (idle_cnt_next >= idle_thr_reg);
                idle_cnt_next = rtty_pkg::sat_inc(idle_cnt_next);
                if (run_hit)
                begin
                    idle_cnt_next    = '0;
                    lock_next        = 1'b0;
                    unknown_cnt_next = '0;
                    figures_next     = 1'b1;
                    state_next       = ST_START;
                end
            end
            else
            begin
                idle_cnt_next    = '0;
                unknown_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            mark_cnt_reg    <= '0;
            space_cnt_reg   <= '0;
            idle_cnt_reg    <= '0;
            unknown_cnt_reg <= '0;
            bit_pos_reg     <= '0;
            code_reg        <= '0;
            figures_reg     <= 1'b1;
            lock_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg       <= state_next;
                mark_cnt_reg    <= mark_cnt_next;
                space_cnt_reg   <= space_cnt_next;
                idle_cnt_reg    <= idle_cnt_next;
                unknown_cnt_reg <= unknown_cnt_next;
                bit_pos_reg     <= bit_pos_next;
                code_reg        <= code_next;
                figures_reg     <= figures_next;
                lock_reg        <= lock_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            char_reg  <= char_next;
            event_reg <= event_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_thr_reg  <= rtty_pkg::IDLE_MARK_RST;
            start_thr_reg <= rtty_pkg::START_SPACE_RST;
            stop_thr_reg  <= rtty_pkg::STOP_MARK_RST;
            nosig_thr_reg <= rtty_pkg::NO_SIGNAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rtty_pkg::CFG_IDLE_MARK:   idle_thr_reg  <= cfg_data;
                rtty_pkg::CFG_START_SPACE: start_thr_reg <= cfg_data;
                rtty_pkg::CFG_STOP_MARK:   stop_thr_reg  <= cfg_data;
                rtty_pkg::CFG_NO_SIGNAL:   nosig_thr_reg <= cfg_data;
                default:                   idle_thr_reg  <= idle_thr_reg;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign ascii_char     = char_reg;
    assign char_valid     = (char_reg != '0);
    assign locked         = lock_reg;
    assign figures_mode   = figures_reg;
    assign sampling_event = event_reg;

    // a decoded character only comes out of a completed, locked frame
    a_char_locked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> locked)
        else $error("character emitted without lock");

    // no code bits at or above the current bit position while shifting in data
    a_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DATA |->
            ((code_reg >> bit_pos_reg) == '0) &&
            (bit_pos_reg < rtty_pkg::BITPOS_W'(rtty_pkg::DATA_BITS)))
        else $error("data shift register out of step with bit position");

    // a start event always leaves the framer at the first data bit
    a_start_enters_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && event_next == rtty_pkg::EV_START |=>
            state_reg == ST_DATA && bit_pos_reg == '0 && code_reg == '0)
        else $error("start bit did not enter data phase cleanly");

endmodule

@@ tb/rtty_baudot_receiver_test.sv @@
// self-checking testbench for the rtty baudot receiver: directed frames, random traffic
`timescale 1ns / 1ps

module rtty_baudot_receiver_test;
    import rtty_pkg::*;

    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_ILLEGAL = 2'd3;

    typedef enum logic [1:0] {PH_INIT, PH_START, PH_DATA, PH_STOP} framer_phase_t;

    typedef struct packed {
        logic               char_valid;
        logic [CHAR_W-1:0]  ascii;
        logic               locked;
        logic               figures;
        logic [EVENT_W-1:0] samp_ev;
    } tty_result_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               pinned;
        tty_result_t        want;
    } probe_row_t;

    localparam tty_result_t QUIET      = '{1'b0, 7'h00, 1'b0, 1'b1, EV_NONE};
    localparam tty_result_t START_SEEN = '{1'b0, 7'h00, 1'b0, 1'b1, EV_START};

    // ita2 letters and figures shift, indexed by the 5-bit code
    localparam logic [CHAR_W-1:0] ITA2_LETTERS [32] = '{
        7'h00, 7'h45, 7'h0A, 7'h41, 7'h20, 7'h53, 7'h49, 7'h55,
        7'h0D, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43, 7'h4B,
        7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50, 7'h51,
        7'h4F, 7'h42, 7'h47, 7'h00, 7'h4D, 7'h58, 7'h56, 7'h00
    };
    localparam logic [CHAR_W-1:0] ITA2_FIGURES [32] = '{
        7'h00, 7'h33, 7'h0A, 7'h2D, 7'h20, 7'h07, 7'h38, 7'h37,
        7'h0D, 7'h24, 7'h34, 7'h27, 7'h2C, 7'h21, 7'h3A, 7'h28,
        7'h35, 7'h22, 7'h29, 7'h32, 7'h23, 7'h36, 7'h30, 7'h31,
        7'h39, 7'h3F, 7'h26, 7'h00, 7'h2E, 7'h2F, 7'h3B, 7'h00
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CLASS_W-1:0]   tone_class;
    logic                 out_valid;
    logic                 out_ready;
    logic                 char_valid;
    logic [CHAR_W-1:0]    ascii_char;
    logic                 locked;
    logic                 figures_mode;
    logic [EVENT_W-1:0]   sampling_event;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    rtty_baudot_receiver DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .tone_class     (tone_class),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .char_valid     (char_valid),
        .ascii_char     (ascii_char),
        .locked         (locked),
        .figures_mode   (figures_mode),
        .sampling_event (sampling_event),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // framer shadow state and thresholds
    framer_phase_t       ph;
    logic [CNT_W-1:0]    marks_n, spaces_n, idle_n, unk_n;
    logic [BITPOS_W-1:0] bit_n;
    logic [CODE_W-1:0]   code_acc;
    logic                fig_q, lock_q;
    logic [CNT_W-1:0]    thr_idle, thr_start, thr_stop, thr_nosig;

    tty_result_t pending_chars [$];
    int          items_sent;
    int          results_checked;
    int          errs;
    bit          steady_send;
    bit          pin_next;
    tty_result_t pin_res;
    probe_row_t  probe_tbl [25];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 25);
    endfunction

    task automatic reset_framer();
        ph        = PH_INIT;
        marks_n   = '0;
        spaces_n  = '0;
        idle_n    = '0;
        unk_n     = '0;
        bit_n     = '0;
        code_acc  = '0;
        fig_q     = 1'b1;
        lock_q    = 1'b0;
        thr_idle  = IDLE_MARK_RST;
        thr_start = START_SPACE_RST;
        thr_stop  = STOP_MARK_RST;
        thr_nosig = NO_SIGNAL_RST;
    endtask

    // one sample through the framer; every threshold test looks at the count before it bumps
    task automatic decode_sample(input logic [CLASS_W-1:0] cls, output tty_result_t res);
        logic               is_sp, is_mk, is_unk, hit, skip;
        logic [CHAR_W-1:0]  ch;
        logic [EVENT_W-1:0] ev;
        is_sp  = (cls == CLS_SPACE);
        is_mk  = (cls == CLS_MARK);
        is_unk = !is_sp && !is_mk;
        ch     = '0;
        ev     = EV_NONE;
        skip   = 1'b0;
        case (ph)
            PH_INIT:
            begin
                if (is_mk)
                begin
                    hit     = (marks_n >= thr_idle);
                    marks_n = bump(marks_n);
                    if (hit)
                    begin
                        marks_n  = '0;
                        spaces_n = '0;
                        bit_n    = '0;
                        code_acc = '0;
                        lock_q   = 1'b0;
                        idle_n   = '0;
                        unk_n    = '0;
                        fig_q    = 1'b1;
                        ph       = PH_START;
                    end
                end
            end
            PH_START:
            begin
                if (is_sp)
                begin
                    hit      = (spaces_n >= thr_start);
                    spaces_n = bump(spaces_n);
                    if (hit)
                    begin
                        ev       = EV_START;
                        marks_n  = '0;
                        spaces_n = '0;
                        unk_n    = '0;
                        bit_n    = '0;
                        code_acc = '0;
                        ph       = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (!is_unk)
                begin
                    if (is_mk)
                    begin
                        code_acc[bit_n] = 1'b1;
                    end
                    bit_n = bit_n + 1'b1;
                    if (bit_n >= BITPOS_W'(DATA_BITS))
                    begin
                        ev       = EV_DATA_DONE;
                        marks_n  = '0;
                        spaces_n = '0;
                        unk_n    = '0;
                        bit_n    = '0;
                        ph       = PH_STOP;
                    end
                end
            end
            default:
            begin
                if (is_mk)
                begin
                    hit     = (marks_n >= thr_stop);
                    marks_n = bump(marks_n);
                    if (hit)
                    begin
                        marks_n  = '0;
                        unk_n    = '0;
                        spaces_n = '0;
                        bit_n    = '0;
                        ph       = PH_START;
                        lock_q   = 1'b1;
                        if (code_acc == CODE_FIGS)
                        begin
                            fig_q = 1'b1;
                        end
                        else if (code_acc == CODE_LTRS)
                        begin
                            fig_q = 1'b0;
                        end
                        else
                        begin
                            ch   = fig_q ? ITA2_FIGURES[code_acc] : ITA2_LETTERS[code_acc];
                            skip = 1'b1;
                        end
                    end
                end
            end
        endcase
        // a decoded character skips the no-signal and idle run checks
        if (!skip)
        begin
            if (is_unk)
            begin
                hit   = (unk_n >= thr_nosig);
                unk_n = bump(unk_n);
                if (hit)
                begin
                    lock_q = 1'b0;
                    fig_q  = 1'b1;
                    idle_n = '0;
                    unk_n  = '0;
                    ph     = PH_INIT;
                end
            end
            else if (is_mk)
            begin
                hit    = (idle_n >= thr_idle);
                idle_n = bump(idle_n);
                if (hit)
                begin
                    idle_n = '0;
                    lock_q = 1'b0;
                    unk_n  = '0;
                    fig_q  = 1'b1;
                    ph     = PH_START;
                end
            end
            else
            begin
                idle_n = '0;
                unk_n  = '0;
            end
        end
        res = '{(ch != '0), ch, lock_q, fig_q, ev};
    endtask

    // offer one sample; valid stays up across back-to-back transfers
    task automatic send_tone(input logic [CLASS_W-1:0] cls);
        int          gap;
        tty_result_t res;
        gap = pause_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        tone_class <= cls;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        decode_sample(cls, res);
        pending_chars.push_back(pin_next ? pin_res : res);
        pin_next = 1'b0;
        items_sent++;
    endtask

    task automatic send_unknown();
        send_tone($urandom_range(0, 1) ? CLS_UNKNOWN : CLS_ILLEGAL);
    endtask

    task automatic send_frame(input logic [CODE_W-1:0] code, input bit broken);
        int nbits;
        nbits = broken ? $urandom_range(1, 4) : DATA_BITS;
        repeat (thr_start + 1 + $urandom_range(0, 1)) send_tone(CLS_SPACE);
        for (int b = 0; b < nbits; b++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_unknown();
            end
            send_tone(code[b] ? CLS_MARK : CLS_SPACE);
        end
        if (broken)
        begin
            repeat ($urandom_range(2, 5)) send_tone(CLASS_W'($urandom_range(0, 3)));
        end
        else
        begin
            repeat (thr_stop + 1 + $urandom_range(0, 1)) send_tone(CLS_MARK);
        end
    endtask

    task automatic run_traffic(input int budget);
        int               stop_at;
        int               r;
        logic [CODE_W-1:0] code;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            steady_send = ($urandom_range(0, 3) == 0);
            if (ph == PH_INIT)
            begin
                repeat (thr_idle + 2) send_tone(CLS_MARK);
            end
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 19))
                0, 1, 2: code = CODE_FIGS;
                3, 4, 5: code = CODE_LTRS;
                6:       code = '0;
                default: code = CODE_W'($urandom_range(0, 31));
            endcase
            if (r < 75)
            begin
                send_frame(code, 1'b0);
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 6)) send_tone(CLASS_W'($urandom_range(0, 3)));
            end
            else if (r < 92)
            begin
                // unknown run long enough to drop back to init while the no-signal threshold is at most 20
                repeat ((thr_nosig > 20 ? 20 : thr_nosig) + 1 + $urandom_range(0, 1))
                    send_unknown();
            end
            else
            begin
                send_frame(code, 1'b1);
            end
        end
        steady_send = 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_IDLE_MARK:   thr_idle  = val;
            CFG_START_SPACE: thr_start = val;
            CFG_STOP_MARK:   thr_stop  = val;
            CFG_NO_SIGNAL:   thr_nosig = val;
            default:         thr_idle  = thr_idle;
        endcase
    endtask

    task automatic program_thresholds(input logic [CNT_W-1:0] idle_v, start_v, stop_v, nosig_v);
        drain();
        write_reg(CFG_IDLE_MARK, idle_v);
        write_reg(CFG_START_SPACE, start_v);
        write_reg(CFG_STOP_MARK, stop_v);
        write_reg(CFG_NO_SIGNAL, nosig_v);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off to back up the input
    initial
    begin
        int          stall_left;
        int          run_left;
        int          r;
        bit          held;
        tty_result_t want;
        stall_left = 0;
        run_left   = 0;
        held       = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errs++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    results_checked++;
                    if (char_valid !== want.char_valid)
                    begin
                        $error("char_valid expected %0d got %0d", want.char_valid, char_valid);
                        errs++;
                    end
                    if (ascii_char !== want.ascii)
                    begin
                        $error("ascii_char expected %h got %h", want.ascii, ascii_char);
                        errs++;
                    end
                    if (locked !== want.locked)
                    begin
                        $error("locked expected %0d got %0d", want.locked, locked);
                        errs++;
                    end
                    if (figures_mode !== want.figures)
                    begin
                        $error("figures_mode expected %0d got %0d", want.figures, figures_mode);
                        errs++;
                    end
                    if (sampling_event !== want.samp_ev)
                    begin
                        $error("sampling_event expected %0d got %0d", want.samp_ev,
                               sampling_event);
                        errs++;
                    end
                end
            end
            if (!held && results_checked >= 200)
            begin
                held       = 1'b1;
                run_left   = 0;
                stall_left = 150;
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    run_left = $urandom_range(1, 4);
                end
                else if (r < 70)
                begin
                    run_left = $urandom_range(20, 60);
                end
                else if (r < 95)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else
                begin
                    stall_left = $urandom_range(10, 40);
                end
            end
            out_ready <= (stall_left == 0);
        end
    end

    initial
    begin
        #5_000_000;
        $display("rtty_baudot_receiver_test: done, errors");
        $finish;
    end

    initial
    begin
        items_sent      = 0;
        results_checked = 0;
        errs            = 0;
        steady_send     = 1'b0;
        pin_next        = 1'b0;
        reset_framer();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        tone_class <= CLS_SPACE;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_IDLE_MARK;
        cfg_data   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: class three and unknown, idle run, start bit, code 1 in
        // figures, then a second start with an unknown right after it
        probe_tbl = '{
            '{CLS_ILLEGAL, 1'b1, QUIET},
            '{CLS_UNKNOWN, 1'b1, QUIET},
            '{CLS_MARK, 1'b1, QUIET}, '{CLS_MARK, 1'b1, QUIET},
            '{CLS_MARK, 1'b1, QUIET}, '{CLS_MARK, 1'b1, QUIET},
            '{CLS_MARK, 1'b1, QUIET}, '{CLS_MARK, 1'b1, QUIET},
            '{CLS_MARK, 1'b1, QUIET}, '{CLS_MARK, 1'b1, QUIET},
            '{CLS_SPACE, 1'b1, QUIET},
            '{CLS_SPACE, 1'b1, START_SEEN},
            '{CLS_MARK, 1'b0, QUIET}, '{CLS_SPACE, 1'b0, QUIET},
            '{CLS_SPACE, 1'b0, QUIET}, '{CLS_SPACE, 1'b0, QUIET},
            '{CLS_SPACE, 1'b0, QUIET},
            '{CLS_MARK, 1'b0, QUIET}, '{CLS_MARK, 1'b0, QUIET},
            '{CLS_MARK, 1'b0, QUIET},
            '{CLS_SPACE, 1'b0, QUIET}, '{CLS_SPACE, 1'b0, QUIET},
            '{CLS_UNKNOWN, 1'b0, QUIET},
            '{CLS_MARK, 1'b0, QUIET}, '{CLS_MARK, 1'b0, QUIET}
        };
        foreach (probe_tbl[i])
        begin
            pin_next = probe_tbl[i].pinned;
            pin_res  = probe_tbl[i].want;
            send_tone(probe_tbl[i].cls);
        end

        run_traffic(130);
        program_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
        run_traffic(110);
        repeat (2)
        begin
            program_thresholds(CNT_W'($urandom_range(1, 4)), CNT_W'($urandom_range(1, 4)),
                               CNT_W'($urandom_range(1, 4)), CNT_W'($urandom_range(1, 4)));
            run_traffic(110);
        end
        program_thresholds(8'd255, 8'd0, 8'd1, 8'd255);
        run_traffic(100);
        // start and stop never qualify here, so only noise is worth sending
        program_thresholds(8'd2, 8'd255, 8'd255, 8'd0);
        repeat (40) send_tone(CLASS_W'($urandom_range(0, 3)));
        program_thresholds(IDLE_MARK_RST, START_SPACE_RST, STOP_MARK_RST, NO_SIGNAL_RST);
        run_traffic(100);
        drain();

        $display("sent %0d tone samples under reset, all-zero, random and extreme thresholds",
                 items_sent);
        $display("compared %0d results, %0d mismatches", results_checked, errs);
        if (errs == 0)
        begin
            $display("rtty_baudot_receiver_test: done, clean");
        end
        else
        begin
            $display("rtty_baudot_receiver_test: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rtty_pkg.sv
rtl/rtty_baudot_receiver.sv
tb/rtty_baudot_receiver_test.sv
